// ===== rtl/core/tcp_connection_table_lookup_macros.svh =====
// assertion macros for the checker file of the connection table
`ifndef TCP_CONNECTION_TABLE_LOOKUP_MACROS_SVH
`define TCP_CONNECTION_TABLE_LOOKUP_MACROS_SVH

// clocked assertion with active-low reset disable
`define TCTL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// expression that must never be true while out of reset
`define TCTL_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `TCTL_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

// ===== rtl/core/tctl_pkg.sv =====
// types and constants of the tcp connection table
package tctl_pkg;

  localparam int unsigned TABLE_SLOTS = 16;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned OP_W        = 2;

  localparam int unsigned IN_DATA_W   = 112;
  localparam int unsigned IN_USER_W   = 3;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned OUT_USER_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] laddr;
    logic [PORT_W-1:0] rport;
    logic [PORT_W-1:0] lport;
    logic              listen;
    logic [ID_W-1:0]   ident;
  } entry_t;

  typedef struct packed {
    logic            hit;
    logic            listen_hit;
    logic [ID_W-1:0] found_id;
    logic            full_res;
  } res_t;

endpackage

// ===== rtl/core/tctl_table.sv =====
// connection entry storage with per-slot match compare lanes
module tctl_table #(
  parameter int unsigned SLOTS = tctl_pkg::TABLE_SLOTS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  ins_en,
  input  tctl_pkg::entry_t                      ins_entry,
  input  logic [SLOTS-1:0]                      clr_vec,
  input  tctl_pkg::entry_t                      qry,
  output logic                                  full,
  output logic [SLOTS-1:0]                      exact_vec,
  output logic [SLOTS-1:0]                      listen_vec,
  output logic [SLOTS-1:0]                      ident_vec,
  output logic [SLOTS-1:0][tctl_pkg::ID_W-1:0]  ident_tbl
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);

  tctl_pkg::entry_t   slot_r [SLOTS];
  logic [SLOTS-1:0]   valid_r;
  logic [SLOTS-1:0]   valid_nxt;
  logic [CNT_W-1:0]   fill_r;
  logic [CNT_W-1:0]   fill_nxt;
  logic [IDX_W-1:0]   wr_idx;
  logic               wr;

  assign full   = (fill_r == CNT_W'(SLOTS));
  assign wr     = ins_en && !full;
  assign wr_idx = fill_r[IDX_W-1:0];

  // freed slots are never refilled: the fill count only grows
  always_comb begin
    valid_nxt = valid_r & ~clr_vec;
    fill_nxt  = fill_r;
    if (wr) begin
      valid_nxt[wr_idx] = 1'b1;
      fill_nxt          = fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      fill_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r[wr_idx] <= ins_entry;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      exact_vec[i]  = valid_r[i] &&
                      (slot_r[i].raddr == qry.raddr) && (slot_r[i].laddr == qry.laddr) &&
                      (slot_r[i].rport == qry.rport) && (slot_r[i].lport == qry.lport);
      listen_vec[i] = valid_r[i] && slot_r[i].listen && (slot_r[i].lport == qry.lport);
      ident_vec[i]  = valid_r[i] && (slot_r[i].ident == qry.ident);
      ident_tbl[i]  = slot_r[i].ident;
    end
  end

endmodule

// ===== rtl/core/tctl_pick.sv =====
// lowest-slot priority select of a match vector and its identifier
module tctl_pick #(
  parameter int unsigned SLOTS = tctl_pkg::TABLE_SLOTS
) (
  input  logic [SLOTS-1:0]                      req,
  input  logic [SLOTS-1:0][tctl_pkg::ID_W-1:0]  ident_tbl,
  output logic                                  any,
  output logic [SLOTS-1:0]                      onehot,
  output logic [tctl_pkg::ID_W-1:0]             id
);

  // isolate the lowest set bit
  assign onehot = req & (~req + SLOTS'(1));
  assign any    = |req;

  always_comb begin
    id = '0;
    for (int i = 0; i < SLOTS; i++) begin
      id = id | (ident_tbl[i] & {tctl_pkg::ID_W{onehot[i]}});
    end
  end

endmodule

// ===== rtl/core/tcp_connection_table_lookup.sv =====
// top level of the tcp connection table: input register, match logic, result register
//
//   channel | group | payload
//   --------+-------+---------------------------------------------------------
//   request | in_   | tdata: addresses, ports, conn_id; tuser: op, listen_flag
//   result  | out_  | tdata: found_id; tuser: hit, listen_hit, full_res
//
// one item per cycle while the result is not stalled; a taken item passes the
// input register, then the parallel slot compare into the result register
// reset clears the slot valid bits, the fill count and the valid bits of both register stages
// a stalled result holds the result register; the input register still takes
// one more item, after which in_tready follows out_tready
module tcp_connection_table_lookup #(
  parameter int unsigned TABLE_SLOTS = tctl_pkg::TABLE_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // source_address, dest_address, source_port, dst_port, conn_id
  input  logic [tctl_pkg::IN_DATA_W-1:0]      in_tdata,
  // op, listen_flag
  input  logic [tctl_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // found_id
  output logic [tctl_pkg::OUT_DATA_W-1:0]     out_tdata,
  // hit, listen_hit, full_res
  output logic [tctl_pkg::OUT_USER_W-1:0]     out_tuser
);

  logic                                      in_valid_r;
  logic [tctl_pkg::OP_W-1:0]                 in_op_r;
  tctl_pkg::entry_t                          in_entry_r;
  tctl_pkg::entry_t                          in_entry;
  logic                                      out_valid_r;
  tctl_pkg::res_t                            out_res_r;
  tctl_pkg::res_t                            res_nxt;
  logic                                      adv;
  logic                                      fire;
  logic                                      ins_en;
  logic [TABLE_SLOTS-1:0]                    clr_vec;
  logic                                      full;
  logic [TABLE_SLOTS-1:0]                    exact_vec;
  logic [TABLE_SLOTS-1:0]                    listen_vec;
  logic [TABLE_SLOTS-1:0]                    ident_vec;
  logic [TABLE_SLOTS-1:0][tctl_pkg::ID_W-1:0] ident_tbl;
  logic                                      exact_any;
  logic                                      listen_any;
  logic                                      rem_any;
  logic [TABLE_SLOTS-1:0]                    exact_oh;
  logic [TABLE_SLOTS-1:0]                    listen_oh;
  logic [TABLE_SLOTS-1:0]                    rem_oh;
  logic [tctl_pkg::ID_W-1:0]                 exact_id;
  logic [tctl_pkg::ID_W-1:0]                 listen_id;
  logic [tctl_pkg::ID_W-1:0]                 rem_id;

  assign adv       = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;

  assign in_entry.raddr  = in_tdata[31:0];
  assign in_entry.laddr  = in_tdata[63:32];
  assign in_entry.rport  = in_tdata[79:64];
  assign in_entry.lport  = in_tdata[95:80];
  assign in_entry.ident  = in_tdata[111:96];
  assign in_entry.listen = in_tuser[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r    <= in_tuser[1:0];
      in_entry_r <= in_entry;
    end
  end

  tctl_table #(
    .SLOTS (TABLE_SLOTS)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .ins_en     (ins_en),
    .ins_entry  (in_entry_r),
    .clr_vec    (clr_vec),
    .qry        (in_entry_r),
    .full       (full),
    .exact_vec  (exact_vec),
    .listen_vec (listen_vec),
    .ident_vec  (ident_vec),
    .ident_tbl  (ident_tbl)
  );

  tctl_pick #(.SLOTS(TABLE_SLOTS)) u_pick_exact (
    .req (exact_vec), .ident_tbl (ident_tbl), .any (exact_any), .onehot (exact_oh),
    .id (exact_id)
  );

  tctl_pick #(.SLOTS(TABLE_SLOTS)) u_pick_listen (
    .req (listen_vec), .ident_tbl (ident_tbl), .any (listen_any), .onehot (listen_oh),
    .id (listen_id)
  );

  tctl_pick #(.SLOTS(TABLE_SLOTS)) u_pick_remove (
    .req (ident_vec), .ident_tbl (ident_tbl), .any (rem_any), .onehot (rem_oh),
    .id (rem_id)
  );

  always_comb begin
    res_nxt = '0;
    ins_en  = 1'b0;
    clr_vec = '0;
    unique case (in_op_r)
      tctl_pkg::OP_LOOKUP: begin
        // full four-tuple match wins over a listening port match
        if (exact_any) begin
          res_nxt.hit      = 1'b1;
          res_nxt.found_id = exact_id;
        end else if (listen_any) begin
          res_nxt.hit        = 1'b1;
          res_nxt.listen_hit = 1'b1;
          res_nxt.found_id   = listen_id;
        end
      end
      tctl_pkg::OP_INSERT: begin
        res_nxt.full_res = full;
        ins_en           = fire && !full;
      end
      tctl_pkg::OP_REMOVE: begin
        res_nxt.hit      = rem_any;
        res_nxt.found_id = rem_any ? rem_id : '0;
        clr_vec          = fire ? rem_oh : '0;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.found_id;
  assign out_tuser  = {out_res_r.full_res, out_res_r.listen_hit, out_res_r.hit};

  // listen_vec onehot is only needed through its identifier
  logic unused_listen_oh;
  assign unused_listen_oh = |listen_oh;

  // exact-match onehot is only needed through its identifier
  logic unused_exact_oh;
  assign unused_exact_oh = |exact_oh;

endmodule

// ===== rtl/core/tctl_checker.sv =====
// port-level checker for the tcp connection table, bound to the top level
`include "tcp_connection_table_lookup_macros.svh"

module tctl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tctl_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [tctl_pkg::OUT_USER_W-1:0]  out_tuser
);

  // a stalled result item holds its value
  `TCTL_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // a refused insert never reports a hit
  `TCTL_ASSERT_NEVER(a_full_no_hit, clk, rst_n, out_tvalid && out_tuser[0] && out_tuser[2], "hit together with full_res")

  // a listening match is always a hit
  `TCTL_ASSERT(a_listen_is_hit, clk, rst_n, out_tvalid && out_tuser[1] |-> out_tuser[0], "listen_hit without hit")

  // no hit means a zero identifier
  `TCTL_ASSERT(a_miss_zero_id, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata == '0, "nonzero found_id on a miss")

endmodule

bind tcp_connection_table_lookup tctl_checker u_tctl_checker (.*);
